FILE: hdl/sfq_pkg.sv
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared widths, reset constants and the queue entry type of the service queue.
// ----------------------------------------------------------------------------
package sfq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int USER_W          = 16;
  localparam int DUR_W           = 8;
  localparam int TICK_W          = 32;
  localparam int PERIOD_W        = 8;
  localparam int STAT_W          = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd3;

  typedef struct packed {
    logic [USER_W-1:0] user;
    logic [DUR_W-1:0]  duration;
    logic [TICK_W-1:0] arrival;
  } job_t;

  typedef struct packed {
    logic en;
    job_t job;
  } push_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic              on_period;
  } tick_info_t;

endpackage

FILE: hdl/sfq_if.sv
// ----------------------------------------------------------------------------
// sfq_if
// Channel interfaces: tick/arrival input and per-tick result output.
// ----------------------------------------------------------------------------
interface sfq_in_if
  import sfq_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              arrival_valid;
  logic [USER_W-1:0] arrival_user;
  logic [DUR_W-1:0]  arrival_duration;

  modport source (output valid, arrival_valid, arrival_user, arrival_duration,
                  input ready);
  modport sink   (input valid, arrival_valid, arrival_user, arrival_duration,
                  output ready);
endinterface

interface sfq_out_if
  import sfq_pkg::*;
  #(parameter int LEVEL_W = 5)
  ();
  logic               valid;
  logic               ready;
  logic               arrival_accepted;
  logic               arrival_dropped;
  logic               start_valid;
  logic [USER_W-1:0]  start_user;
  logic [TICK_W-1:0]  start_wait;
  logic               finish_valid;
  logic [USER_W-1:0]  finish_user;
  logic               server_busy;
  logic [LEVEL_W-1:0] queue_level;
  logic [STAT_W-1:0]  wait_total;
  logic [STAT_W-1:0]  started_total;
  logic [TICK_W-1:0]  tick_now;

  modport source (output valid, arrival_accepted, arrival_dropped, start_valid,
                  start_user, start_wait, finish_valid, finish_user, server_busy,
                  queue_level, wait_total, started_total, tick_now,
                  input ready);
  modport sink   (input valid, arrival_accepted, arrival_dropped, start_valid,
                  start_user, start_wait, finish_valid, finish_user, server_busy,
                  queue_level, wait_total, started_total, tick_now,
                  output ready);
endinterface

FILE: hdl/sfq_queue.sv
// ----------------------------------------------------------------------------
// sfq_queue
// Job FIFO with a registered head read, prefetched one transfer ahead.
// ----------------------------------------------------------------------------
module sfq_queue
  import sfq_pkg::*;
  #(parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1))
  (
    input  logic               clk,
    input  logic               rst,
    input  push_t              push,
    input  logic               pop,
    output logic [LEVEL_W-1:0] count,
    output job_t               head_job
  );

  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (pop) begin
      head_next = (head == LAST) ? '0 : head + PTR_W'(1);
    end
    if (push.en) begin
      tail_next = (tail == LAST) ? '0 : tail + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count + LEVEL_W'(push.en) - LEVEL_W'(pop);
    end
  end

  // head entry is read for the next tick; a write landing there is forwarded
  always_ff @(posedge clk) begin
    if (push.en) begin
      mem[tail] <= push.job;
    end
    if (push.en && (tail == head_next)) begin
      head_job <= push.job;
    end else begin
      head_job <= mem[head_next];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.en && !pop |-> count < LEVEL_W'(QUEUE_DEPTH))
    else $error("push into full queue");

endmodule

FILE: hdl/sfq_server.sv
// ----------------------------------------------------------------------------
// sfq_server
// Per-tick admission, server countdown, statistics and result register.
// ----------------------------------------------------------------------------
module sfq_server
  import sfq_pkg::*;
  #(parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1))
  (
    input  logic               clk,
    input  logic               rst,
    sfq_in_if.sink             job_in,
    sfq_out_if.source          tick_out,
    input  tick_info_t         tinfo,
    output logic               xfer,
    output push_t              push,
    output logic               pop,
    input  logic [LEVEL_W-1:0] count,
    input  job_t               head_job
  );

  logic              busy;
  logic [DUR_W-1:0]  remaining;
  logic [USER_W-1:0] cur_user;
  logic [STAT_W-1:0] wait_sum;
  logic [STAT_W-1:0] started_count;

  logic              busy_next;
  logic [DUR_W-1:0]  remaining_next;
  logic [USER_W-1:0] cur_user_next;
  logic [STAT_W-1:0] wait_sum_next;
  logic [STAT_W-1:0] started_count_next;

  logic              offer;
  logic              start;
  logic              finish;
  logic              busy_s;
  logic [DUR_W-1:0]  rem_s;
  job_t              sjob;
  logic [TICK_W-1:0] wait_t;
  logic [STAT_W:0]   wsum;
  logic [LEVEL_W-1:0] level_next;

  assign job_in.ready = !tick_out.valid || tick_out.ready;
  assign xfer         = job_in.valid && job_in.ready;

  always_comb begin
    offer             = job_in.arrival_valid;
    push.job.user     = job_in.arrival_user;
    push.job.duration = (job_in.arrival_duration == '0) ? DUR_W'(1)
                                                        : job_in.arrival_duration;
    push.job.arrival  = tinfo.tick;
    push.en           = xfer && offer && tinfo.on_period
                        && (count < LEVEL_W'(QUEUE_DEPTH));

    // an arrival into an empty queue can start in its own tick
    start = !busy && ((count != '0) || push.en);
    pop   = xfer && start;
    sjob  = (count != '0) ? head_job : push.job;
    wait_t = tinfo.tick - sjob.arrival;

    busy_s        = busy || start;
    rem_s         = start ? sjob.duration : remaining;
    cur_user_next = start ? sjob.user : cur_user;
    finish        = busy_s && (rem_s <= DUR_W'(1));

    busy_next      = busy_s && !finish;
    remaining_next = remaining;
    if (finish) begin
      remaining_next = '0;
    end else if (busy_s) begin
      remaining_next = rem_s - DUR_W'(1);
    end

    wsum               = {1'b0, wait_sum} + {1'b0, wait_t};
    wait_sum_next      = wait_sum;
    started_count_next = started_count;
    if (start) begin
      wait_sum_next = wsum[STAT_W] ? '1 : wsum[STAT_W-1:0];
      if (started_count != '1) begin
        started_count_next = started_count + STAT_W'(1);
      end
    end

    level_next = count + LEVEL_W'(push.en) - LEVEL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      remaining      <= '0;
      cur_user       <= '0;
      wait_sum       <= '0;
      started_count  <= '0;
      tick_out.valid <= 1'b0;
    end else begin
      if (xfer) begin
        busy          <= busy_next;
        remaining     <= remaining_next;
        cur_user      <= cur_user_next;
        wait_sum      <= wait_sum_next;
        started_count <= started_count_next;
      end
      if (xfer) begin
        tick_out.valid <= 1'b1;
      end else if (tick_out.ready) begin
        tick_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      tick_out.arrival_accepted <= push.en;
      tick_out.arrival_dropped  <= offer && !push.en;
      tick_out.start_valid      <= start;
      tick_out.start_user       <= start ? sjob.user : '0;
      tick_out.start_wait       <= start ? wait_t : '0;
      tick_out.finish_valid     <= finish;
      tick_out.finish_user      <= finish ? cur_user_next : '0;
      tick_out.server_busy      <= busy_next;
      tick_out.queue_level      <= level_next;
      tick_out.wait_total       <= wait_sum_next;
      tick_out.started_total    <= started_count_next;
      tick_out.tick_now         <= tinfo.tick;
    end
  end

  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> remaining != '0)
    else $error("server busy with zero remaining ticks");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0) || push.en)
    else $error("dequeue from empty queue");

  a_start_consistent: assert property (@(posedge clk) disable iff (rst)
    tick_out.valid && tick_out.start_valid
      |-> tick_out.server_busy || tick_out.finish_valid)
    else $error("started job neither busy nor finished");

endmodule

FILE: hdl/single_server_fifo_service_queue_top.sv
// ----------------------------------------------------------------------------
// single_server_fifo_service_queue_top
// One-server FIFO service queue advanced one tick per input transfer.
//
//   channel   dir  handshake     payload
//   job_in    in   valid/ready   arrival_valid, arrival_user, arrival_duration
//   tick_out  out  valid/ready   accept/drop, start, finish, level, totals, tick
//   cfg       in   cfg_we        cfg_data = arrival_period
//
// One tick per cycle while the output is not stalled: the tick is decided in the
// transfer cycle and lands in the result register. A result held by a stalled
// output holds off the next input transfer; a result taken in the same cycle
// lets the next tick through. The head entry of the job memory is read one
// transfer ahead, so the memory read port sets no extra latency. Synchronous
// reset; no clearing pass, queue entries are read only once written.
// ----------------------------------------------------------------------------
module single_server_fifo_service_queue_top
  import sfq_pkg::*;
  #(parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF)
  (
    input  logic                clk,
    input  logic                rst,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_data,
    sfq_in_if.sink              job_in,
    sfq_out_if.source           tick_out
  );

  localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] phase;
  logic [PERIOD_W-1:0] period_eff;
  logic [PERIOD_W:0]   phase_inc;
  logic [TICK_W-1:0]   tick;
  logic                xfer;
  logic                pop;
  logic [LEVEL_W-1:0]  count;
  push_t               push;
  job_t                head_job;
  tick_info_t          tinfo;

  assign period_eff      = (period == '0) ? PERIOD_W'(1) : period;
  assign phase_inc       = {1'b0, phase} + (PERIOD_W+1)'(1);
  assign tinfo.tick      = tick;
  assign tinfo.on_period = (phase == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
      phase  <= '0;
      tick   <= '0;
    end else begin
      if (cfg_we) begin
        period <= cfg_data;
      end
      if (xfer) begin
        tick  <= tick + TICK_W'(1);
        phase <= (phase_inc >= {1'b0, period_eff}) ? '0 : phase_inc[PERIOD_W-1:0];
      end
    end
  end

  sfq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .count    (count),
    .head_job (head_job)
  );

  sfq_server #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_server (
    .clk      (clk),
    .rst      (rst),
    .job_in   (job_in),
    .tick_out (tick_out),
    .tinfo    (tinfo),
    .xfer     (xfer),
    .push     (push),
    .pop      (pop),
    .count    (count),
    .head_job (head_job)
  );

endmodule
